// ===== src/pkqs_pkg.sv =====
package pkqs_pkg;

    // default sizing
    localparam int MAX_KEYS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    // register
    localparam int          SRV_W       = 5;
    localparam logic [4:0]  SRV_RESET   = 5'd4;

    // beat layout
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 4;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    // action codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_NEXT    = 1'b1;

    // status codes
    localparam logic [2:0] ST_ENQUEUED  = 3'd0;
    localparam logic [2:0] ST_DELIVERED = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_QFULL     = 3'd3;
    localparam logic [2:0] ST_TFULL     = 3'd4;

endpackage

// ===== src/pkqs_ram.sv =====
module pkqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/per_key_put_get_alternating_scheduler.sv =====
// per-key put/get alternating scheduler, round robin over key slots
// enqueue beat: the lookup walks the key memory one entry per compare (S_K_RD, S_K_CMP), then
//   reads and updates the slot metadata (S_M_RD, S_M_ENQ); a new key first takes a fresh slot,
//   a full table goes straight to the result; next beat: the scan reads and checks each slot
//   (S_N_RD, S_N_USE), then reads the store word on delivery (S_N_DAT); slot state comes from the metadata memory
// one beat in flight at a time; a finished result waits in the output register
// reset (rst_n low, async) empties the key table and restores num_mem_servers to 4
module per_key_put_get_alternating_scheduler #(
    parameter int MAX_KEYS    = pkqs_pkg::MAX_KEYS_DEF,
    parameter int QUEUE_DEPTH = pkqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel: num_mem_servers
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pkqs_pkg::SRV_W-1:0]        cfg_data,
    // input beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pkqs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key[31:0], payload[63:32]
    input  logic [pkqs_pkg::IN_USER_W-1:0]    s_axis_tuser,  // action[0], is_put[1]
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pkqs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // out_payload[31:0], out_slot[35:32]
    output logic [pkqs_pkg::OUT_USER_W-1:0]   m_axis_tuser   // status[2:0], out_is_put[3]
);

    localparam int SW  = $clog2(MAX_KEYS);
    localparam int KCW = $clog2(MAX_KEYS + 1);
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = $clog2(MAX_KEYS * QUEUE_DEPTH);
    localparam int SRVW = pkqs_pkg::SRV_W;
    localparam int SLOT_OUT_W_L = pkqs_pkg::SLOT_OUT_W;

    // per-slot queue bookkeeping, one word per slot in the metadata memory
    typedef struct packed {
        logic [HW-1:0]   put_head;
        logic [FW-1:0]   put_fill;
        logic [HW-1:0]   get_head;
        logic [FW-1:0]   get_fill;
        logic [SRVW-1:0] served;
        logic            put_phase;
        logic            first_put;
    } meta_t;

    localparam int MW = $bits(meta_t);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_K_RD  = 9'b000000010,
        S_K_CMP = 9'b000000100,
        S_M_RD  = 9'b000001000,
        S_M_ENQ = 9'b000010000,
        S_N_RD  = 9'b000100000,
        S_N_USE = 9'b001000000,
        S_N_DAT = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SRVW-1:0] nms_reg;
    logic [SRVW-1:0] eff_srv;

    // latched beat
    logic        isput_reg, isput_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] pl_reg, pl_next;

    // scheduler control
    logic [KCW-1:0] key_count_reg, key_count_next;
    logic [KCW-1:0] kidx_reg, kidx_next;
    logic [KCW-1:0] tries_reg, tries_next;
    logic [SW-1:0]  ptr_reg, ptr_next;
    logic [SW-1:0]  slot_reg, slot_next;

    // pending result
    logic [2:0]  res_status_reg, res_status_next;
    logic        res_isput_reg, res_isput_next;
    logic [31:0] res_pl_reg, res_pl_next;
    logic [SLOT_OUT_W_L-1:0] res_slot_reg, res_slot_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic        out_isput_reg;
    logic [31:0] out_pl_reg;
    logic [SLOT_OUT_W_L-1:0] out_slot_reg;
    logic        out_free;

    // memory ports
    logic          key_we;
    logic [SW-1:0] key_waddr, key_raddr;
    logic [31:0]   key_rdata;
    logic          meta_we;
    logic [SW-1:0] meta_waddr, meta_raddr;
    meta_t         meta_wdata, meta_rdata;
    logic          put_we, get_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0]   put_rdata, get_rdata;

    // datapath helpers
    logic [7:0]      cap;
    logic [FW-1:0]   enq_fill;
    logic [HW-1:0]   enq_head;
    logic [FW:0]     off_sum;
    logic [HW-1:0]   off;
    logic [AW-1:0]   slot_base;
    logic [AW-1:0]   ptr_base;
    logic [SW-1:0]   ptr_adv;
    logic [FW-1:0]   pop_fill;
    logic [HW-1:0]   pop_head;
    logic [HW-1:0]   pop_head_inc;
    logic [SRVW-1:0] srv_inc;
    meta_t           meta_clear, meta_enq, meta_pop;
    logic [SW+SLOT_OUT_W_L-1:0] slot_ext, ptr_ext;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pkqs_pkg::OUT_DATA_W - 36){1'b0}}, out_slot_reg, out_pl_reg};
    assign m_axis_tuser  = {out_isput_reg, out_status_reg};

    // zero register behaves as one pop per phase
    assign eff_srv = (nms_reg == '0) ? SRVW'(1) : nms_reg;
    assign cap     = (8'(eff_srv) > 8'(QUEUE_DEPTH)) ? 8'(QUEUE_DEPTH) : 8'(eff_srv);

    assign slot_ext = {{SLOT_OUT_W_L{1'b0}}, slot_reg};
    assign ptr_ext  = {{SLOT_OUT_W_L{1'b0}}, ptr_reg};

    assign slot_base = AW'(AW'(slot_reg) * AW'(QUEUE_DEPTH));
    assign ptr_base  = AW'(AW'(ptr_reg) * AW'(QUEUE_DEPTH));

    // enqueue side: tail offset = (head + fill) mod depth
    assign enq_fill = isput_reg ? meta_rdata.put_fill : meta_rdata.get_fill;
    assign enq_head = isput_reg ? meta_rdata.put_head : meta_rdata.get_head;
    assign off_sum  = (FW+1)'(enq_head) + (FW+1)'(enq_fill);
    assign off      = (off_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                      HW'(off_sum - (FW+1)'(QUEUE_DEPTH)) : HW'(off_sum);

    always_comb
    begin
        meta_clear           = '0;
        meta_clear.put_phase = 1'b1;
        meta_clear.first_put = 1'b1;
        meta_enq             = meta_rdata;
        if (isput_reg)
        begin
            meta_enq.put_fill = meta_rdata.put_fill + FW'(1);
        end
        else
        begin
            meta_enq.get_fill = meta_rdata.get_fill + FW'(1);
        end
    end

    // pop side
    assign ptr_adv      = ((KCW'(ptr_reg) + KCW'(1)) == key_count_reg) ? '0 : SW'(ptr_reg + SW'(1));
    assign pop_fill     = meta_rdata.put_phase ? meta_rdata.put_fill : meta_rdata.get_fill;
    assign pop_head     = meta_rdata.put_phase ? meta_rdata.put_head : meta_rdata.get_head;
    assign pop_head_inc = ((HW+1)'(pop_head) + (HW+1)'(1) == (HW+1)'(QUEUE_DEPTH)) ?
                          '0 : HW'(pop_head + HW'(1));
    assign srv_inc      = meta_rdata.served + SRVW'(1);

    always_comb
    begin
        meta_pop        = meta_rdata;
        meta_pop.served = srv_inc;
        if (meta_rdata.put_phase)
        begin
            meta_pop.put_head = pop_head_inc;
            meta_pop.put_fill = meta_rdata.put_fill - FW'(1);
            // the very first put of a slot hands over to gets at once
            if (meta_rdata.first_put)
            begin
                meta_pop.put_phase = 1'b0;
                meta_pop.served    = '0;
                meta_pop.first_put = 1'b0;
            end
            else if (srv_inc >= eff_srv)
            begin
                meta_pop.put_phase = 1'b0;
                meta_pop.served    = '0;
            end
        end
        else
        begin
            meta_pop.get_head = pop_head_inc;
            meta_pop.get_fill = meta_rdata.get_fill - FW'(1);
            if (srv_inc >= eff_srv)
            begin
                meta_pop.put_phase = 1'b1;
                meta_pop.served    = '0;
            end
        end
    end

    // memory addressing
    assign key_raddr  = kidx_reg[SW-1:0];
    assign key_waddr  = key_count_reg[SW-1:0];
    assign meta_raddr = (state_reg == S_N_RD) ? ptr_reg : slot_reg;
    assign st_waddr   = slot_base + AW'(off);
    assign st_raddr   = ptr_base + AW'(pop_head);

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        isput_next      = isput_reg;
        key_next        = key_reg;
        pl_next         = pl_reg;
        key_count_next  = key_count_reg;
        kidx_next       = kidx_reg;
        tries_next      = tries_reg;
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_isput_next  = res_isput_reg;
        res_pl_next     = res_pl_reg;
        res_slot_next   = res_slot_reg;
        key_we          = 1'b0;
        meta_we         = 1'b0;
        meta_waddr      = slot_reg;
        meta_wdata      = meta_enq;
        put_we          = 1'b0;
        get_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    isput_next     = s_axis_tuser[1];
                    key_next       = s_axis_tdata[31:0];
                    pl_next        = s_axis_tdata[63:32];
                    res_isput_next = 1'b0;
                    res_pl_next    = '0;
                    res_slot_next  = '0;
                    if (s_axis_tuser[0] == pkqs_pkg::ACT_ENQUEUE)
                    begin
                        kidx_next  = '0;
                        state_next = S_K_RD;
                    end
                    else if (key_count_reg == '0)
                    begin
                        res_status_next = pkqs_pkg::ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        if (KCW'(ptr_reg) >= key_count_reg)
                        begin
                            ptr_next = '0;
                        end
                        tries_next = '0;
                        state_next = S_N_RD;
                    end
                end
            end

            S_K_RD:
            begin
                if (kidx_reg >= key_count_reg)
                begin
                    // unseen key: take a fresh slot or report a full table
                    if (key_count_reg >= KCW'(MAX_KEYS))
                    begin
                        res_status_next = pkqs_pkg::ST_TFULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        key_we         = 1'b1;
                        meta_we        = 1'b1;
                        meta_waddr     = key_count_reg[SW-1:0];
                        meta_wdata     = meta_clear;
                        slot_next      = key_count_reg[SW-1:0];
                        key_count_next = key_count_reg + KCW'(1);
                        state_next     = S_M_RD;
                    end
                end
                else
                begin
                    state_next = S_K_CMP;
                end
            end

            S_K_CMP:
            begin
                if (key_rdata == key_reg)
                begin
                    slot_next  = kidx_reg[SW-1:0];
                    state_next = S_M_RD;
                end
                else
                begin
                    kidx_next  = kidx_reg + KCW'(1);
                    state_next = S_K_RD;
                end
            end

            S_M_RD:
            begin
                state_next = S_M_ENQ;
            end

            S_M_ENQ:
            begin
                res_slot_next = slot_ext[SLOT_OUT_W_L-1:0];
                if (8'(enq_fill) >= cap)
                begin
                    res_status_next = pkqs_pkg::ST_QFULL;
                end
                else
                begin
                    put_we          = isput_reg;
                    get_we          = !isput_reg;
                    meta_we         = 1'b1;
                    meta_wdata      = meta_enq;
                    res_status_next = pkqs_pkg::ST_ENQUEUED;
                end
                state_next = S_RESP;
            end

            S_N_RD:
            begin
                state_next = S_N_USE;
            end

            S_N_USE:
            begin
                ptr_next = ptr_adv;
                if (pop_fill == '0)
                begin
                    tries_next = tries_reg + KCW'(1);
                    if ((tries_reg + KCW'(1)) == key_count_reg)
                    begin
                        res_status_next = pkqs_pkg::ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_N_RD;
                    end
                end
                else
                begin
                    meta_we         = 1'b1;
                    meta_waddr      = ptr_reg;
                    meta_wdata      = meta_pop;
                    res_status_next = pkqs_pkg::ST_DELIVERED;
                    res_isput_next  = meta_rdata.put_phase;
                    res_slot_next   = ptr_ext[SLOT_OUT_W_L-1:0];
                    state_next      = S_N_DAT;
                end
            end

            S_N_DAT:
            begin
                res_pl_next = res_isput_reg ? put_rdata : get_rdata;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nms_reg       <= pkqs_pkg::SRV_RESET;
            key_count_reg <= '0;
            ptr_reg       <= '0;
            kidx_reg      <= '0;
            tries_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            ptr_reg       <= ptr_next;
            kidx_reg      <= kidx_next;
            tries_reg     <= tries_next;
            slot_reg      <= slot_next;
            if (cfg_valid && cfg_ready)
            begin
                nms_reg <= cfg_data;
            end
            // result register frees up when taken, reloads from the pending result
            if (state_reg == S_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        isput_reg      <= isput_next;
        key_reg        <= key_next;
        pl_reg         <= pl_next;
        res_status_reg <= res_status_next;
        res_isput_reg  <= res_isput_next;
        res_pl_reg     <= res_pl_next;
        res_slot_reg   <= res_slot_next;
        if (state_reg == S_RESP && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_isput_reg  <= res_isput_reg;
            out_pl_reg     <= res_pl_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    // key table
    pkqs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // per-slot heads, fills, served count and phase
    pkqs_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_KEYS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // put queues, QUEUE_DEPTH entries per slot
    pkqs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEYS * QUEUE_DEPTH)
    ) u_put_ram (
        .clk   (clk),
        .we    (put_we),
        .waddr (st_waddr),
        .wdata (pl_reg),
        .raddr (st_raddr),
        .rdata (put_rdata)
    );

    // get queues
    pkqs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEYS * QUEUE_DEPTH)
    ) u_get_ram (
        .clk   (clk),
        .we    (get_we),
        .waddr (st_waddr),
        .wdata (pl_reg),
        .raddr (st_raddr),
        .rdata (get_rdata)
    );

    // key table never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KCW'(MAX_KEYS))
    else $error("key count beyond table size");

    // the scan only visits slots that hold a key
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_N_RD) |-> (KCW'(ptr_reg) < key_count_reg))
    else $error("scan pointer outside used slots");

    // store data is always followed by a result hand-off
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_N_DAT) |=> (state_reg == S_RESP))
    else $error("pop data not forwarded");

    // a released result lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> out_valid_reg)
    else $error("result lost on release");

endmodule
